// ----- rtl/grg_pkg.sv -----
`timescale 1ns / 1ps
package grg_pkg;

  localparam int STOP_W = 13;
  localparam int INDEX_W = 12;
  localparam int GAMMA_W = 16;
  localparam int LEVEL_W = 18;
  localparam int RAMP_W = 16;
  localparam int X_W = 24;
  localparam int NLOG_W = 35;
  localparam int Y_W = NLOG_W + 12;
  localparam int POWER_W = 33;

  localparam logic [STOP_W-1:0] MAX_STOPS = 13'd4096;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
  localparam logic [POWER_W-1:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [RAMP_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [RAMP_W-1:0] ZERO_LEVEL = 16'h0000;

  typedef enum logic [1:0] {
    REG_STOP_COUNT = 2'd0,
    REG_GAMMA = 2'd1,
    REG_BLACK = 2'd2,
    REG_WHITE = 2'd3
  } grg_reg_t;

  typedef struct packed {
    logic zero;
    logic full;
  } grg_flags_t;

endpackage

// ----- rtl/grg_div.sv -----
`timescale 1ns / 1ps
module grg_div import grg_pkg::*; #(
  parameter int N = 36,
  parameter int M = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  input  grg_flags_t   in_flags,
  output logic         out_valid,
  output logic [N-1:0] quotient,
  output grg_flags_t   out_flags
);

  logic         vld [N];
  logic [M-1:0] rem [N];
  logic [N-1:0] dq  [N];
  grg_flags_t   flg [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic         cv;
    logic [M-1:0] crem;
    logic [N-1:0] cd;
    grg_flags_t   cf;
    logic [M:0]   trial;
    logic [M:0]   diff;
    logic         ge;

    if (s == 0) begin : g_first
      assign cv = in_valid;
      assign crem = '0;
      assign cd = dividend;
      assign cf = in_flags;
    end else begin : g_next
      assign cv = vld[s-1];
      assign crem = rem[s-1];
      assign cd = dq[s-1];
      assign cf = flg[s-1];
    end

    assign trial = {crem, cd[N-1]};
    assign ge = trial >= {1'b0, divisor};
    assign diff = trial - {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? diff[M-1:0] : trial[M-1:0];
        dq[s] <= {cd[N-2:0], ge};
        flg[s] <= cf;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quotient = dq[N-1];
  assign out_flags = flg[N-1];

endmodule

// ----- rtl/grg_log2.sv -----
`timescale 1ns / 1ps
module grg_log2 import grg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [X_W-1:0]    x,
  input  grg_flags_t        in_flags,
  output logic              out_valid,
  output logic [NLOG_W-1:0] neg_log,
  output grg_flags_t        out_flags
);

  localparam int STEPS = 30;

  logic [4:0]  msb;
  logic [30:0] m_init;
  logic        v0;
  logic [30:0] m0;
  logic [4:0]  e0;
  grg_flags_t  f0;

  always_comb begin
    msb = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) begin
        msb = 5'(i);
      end
    end
  end

  assign m_init = {7'b0, x} << (5'd30 - msb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= m_init;
      e0 <= 5'd24 - msb;
      f0 <= in_flags;
    end
  end

  logic        vld  [STEPS];
  logic [30:0] mant [STEPS];
  logic [29:0] frac [STEPS];
  logic [4:0]  expo [STEPS];
  grg_flags_t  flg  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic        cv;
    logic [30:0] cm;
    logic [29:0] cfr;
    logic [4:0]  ce;
    grg_flags_t  cf;
    logic [61:0] sq;
    logic [31:0] sh;

    if (s == 0) begin : g_first
      assign cv = v0;
      assign cm = m0;
      assign cfr = '0;
      assign ce = e0;
      assign cf = f0;
    end else begin : g_next
      assign cv = vld[s-1];
      assign cm = mant[s-1];
      assign cfr = frac[s-1];
      assign ce = expo[s-1];
      assign cf = flg[s-1];
    end

    assign sq = cm * cm;
    assign sh = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mant[s] <= sh[31] ? sh[31:1] : sh[30:0];
        frac[s] <= {cfr[28:0], sh[31]};
        expo[s] <= ce;
        flg[s] <= cf;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign neg_log = {expo[STEPS-1], 30'b0} - {5'b0, frac[STEPS-1]};
  assign out_flags = flg[STEPS-1];

endmodule

// ----- rtl/grg_exp2.sv -----
`timescale 1ns / 1ps
module grg_exp2 import grg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [Y_W-1:0]     y,
  input  grg_flags_t         in_flags,
  output logic               out_valid,
  output logic [POWER_W-1:0] power,
  output grg_flags_t         out_flags
);

  localparam int TERMS = 14;

  typedef struct packed {
    logic [31:0] t;
    logic [33:0] sum;
    logic [4:0]  nsh;
    logic        big;
    grg_flags_t  flags;
  } exp_ctx_t;

  logic [61:0] f_prod;
  logic        v0;
  exp_ctx_t    ctx0;

  assign f_prod = y[29:0] * LN2_Q32;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx0.t <= f_prod[61:30];
      ctx0.sum <= {1'b0, ONE_Q32};
      ctx0.nsh <= y[34:30];
      ctx0.big <= |y[Y_W-1:35];
      ctx0.flags <= in_flags;
    end
  end

  logic        va [TERMS];
  exp_ctx_t    ca [TERMS];
  logic [31:0] pa_v [TERMS];
  logic        vb [TERMS];
  exp_ctx_t    cb [TERMS];
  logic [31:0] pb_v [TERMS];
  logic [31:0] pb_q [TERMS];
  logic        vc [TERMS];
  exp_ctx_t    cc [TERMS];
  logic [POWER_W-1:0] term_c [TERMS];

  for (genvar j = 0; j < TERMS; j++) begin : g_term
    localparam logic [33:0] RECIP = 34'((64'h3_FFFF_FFFF) / (j + 1));
    localparam logic [3:0] KVAL = 4'(j + 1);
    localparam logic [31:0] K32 = 32'(j + 1);

    logic               cv;
    exp_ctx_t           cx;
    logic [POWER_W-1:0] cterm;
    logic [64:0]        pa;
    logic [65:0]        pb;
    logic [35:0]        pk;
    logic [31:0]        r;
    logic [31:0]        qn;
    exp_ctx_t           nx;

    if (j == 0) begin : g_first
      assign cv = v0;
      assign cx = ctx0;
      assign cterm = ONE_Q32;
    end else begin : g_next
      assign cv = vc[j-1];
      assign cx = cc[j-1];
      assign cterm = term_c[j-1];
    end

    assign pa = cterm * cx.t;
    assign pb = pa_v[j] * RECIP;
    assign pk = pb_q[j] * KVAL;
    assign r = pb_v[j] - pk[31:0];
    assign qn = pb_q[j] + {31'b0, r >= K32};

    if ((j % 2) == 0) begin : g_odd
      always_comb begin
        nx = cb[j];
        nx.sum = cb[j].sum - {2'b0, qn};
      end
    end else begin : g_even
      always_comb begin
        nx = cb[j];
        nx.sum = cb[j].sum + {2'b0, qn};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va[j] <= 1'b0;
        vb[j] <= 1'b0;
        vc[j] <= 1'b0;
      end else if (en) begin
        va[j] <= cv;
        vb[j] <= va[j];
        vc[j] <= vb[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ca[j] <= cx;
        pa_v[j] <= pa[63:32];
        cb[j] <= ca[j];
        pb_v[j] <= pa_v[j];
        pb_q[j] <= pb[65:34];
        cc[j] <= nx;
        term_c[j] <= {1'b0, qn};
      end
    end
  end

  logic               vf;
  logic [POWER_W-1:0] pw;
  grg_flags_t         ff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vc[TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw <= cc[TERMS-1].big ? '0 : (cc[TERMS-1].sum[POWER_W-1:0] >> cc[TERMS-1].nsh);
      ff <= cc[TERMS-1].flags;
    end
  end

  assign out_valid = vf;
  assign power = pw;
  assign out_flags = ff;

endmodule

// ----- rtl/gamma_ramp_generator_core.sv -----
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_stall    stop_index
// out      out_valid / out_stall  ramp_level, clipped
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One stop index enters every cycle while the output is not stalled.
// The pipeline runs through the two bit-per-stage dividers and the 30 squaring stages of log2.
// Reset clears all valid bits and loads the default configuration.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module gamma_ramp_generator_core import grg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [INDEX_W-1:0] stop_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RAMP_W-1:0]  ramp_level,
  output logic               clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  grg_reg_t           cfg_index,
  input  logic [LEVEL_W-1:0] cfg_data
);

  logic [STOP_W-1:0]         stop_count;
  logic [GAMMA_W-1:0]        gamma_q4_12;
  logic signed [LEVEL_W-1:0] black_level;
  logic signed [LEVEL_W-1:0] white_level;
  logic [STOP_W-1:0]         stops_in;
  logic                      en;

  assign cfg_ready = 1'b1;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_comb begin
    stops_in = cfg_data[STOP_W-1:0];
    if (stops_in == '0) begin
      stops_in = STOP_W'(1);
    end else if (stops_in > MAX_STOPS) begin
      stops_in = MAX_STOPS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= 13'd256;
      gamma_q4_12 <= 16'd9011;
      black_level <= '0;
      white_level <= 18'sd65535;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STOP_COUNT: stop_count <= stops_in;
        REG_GAMMA: gamma_q4_12 <= (cfg_data[GAMMA_W-1:0] == '0) ? GAMMA_W'(1)
                                                                 : cfg_data[GAMMA_W-1:0];
        REG_BLACK: black_level <= cfg_data;
        REG_WHITE: white_level <= cfg_data;
        default: ;
      endcase
    end
  end

  logic               v0;
  logic [INDEX_W-1:0] idx0;
  grg_flags_t         f0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0 <= stop_index;
      f0.zero <= stop_index == '0;
      f0.full <= {1'b0, stop_index} >= stop_count;
    end
  end

  logic                 xv;
  logic [INDEX_W+X_W-1:0] xq;
  grg_flags_t           xf;

  grg_div #(.N(INDEX_W + X_W), .M(STOP_W)) u_xdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .dividend({idx0, {X_W{1'b0}}}), .divisor(stop_count), .in_flags(f0),
    .out_valid(xv), .quotient(xq), .out_flags(xf)
  );

  logic              lv;
  logic [NLOG_W-1:0] nl;
  grg_flags_t        lf;

  grg_log2 u_log2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(xv), .x(xq[X_W-1:0]), .in_flags(xf),
    .out_valid(lv), .neg_log(nl), .out_flags(lf)
  );

  logic           yv;
  logic [Y_W-1:0] y;
  grg_flags_t     yf;

  grg_div #(.N(Y_W), .M(GAMMA_W)) u_ydiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(lv), .dividend({nl, 12'b0}), .divisor(gamma_q4_12), .in_flags(lf),
    .out_valid(yv), .quotient(y), .out_flags(yf)
  );

  logic               ev;
  logic [POWER_W-1:0] ep;
  grg_flags_t         ef;

  grg_exp2 u_exp2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(yv), .y(y), .in_flags(yf),
    .out_valid(ev), .power(ep), .out_flags(ef)
  );

  logic [POWER_W-1:0]        pw;
  logic signed [LEVEL_W:0]   diff;
  logic signed [52:0]        prod;
  logic signed [52:0]        prod_r;
  logic                      v1;

  always_comb begin
    priority if (ef.zero) begin
      pw = '0;
    end else if (ef.full) begin
      pw = ONE_Q32;
    end else begin
      pw = ep;
    end
  end

  assign diff = {white_level[LEVEL_W-1], white_level} - {black_level[LEVEL_W-1], black_level};
  assign prod = $signed({1'b0, pw}) * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
    end
  end

  logic signed [53:0] total;
  logic signed [53:0] adj;
  logic [21:0]        q;
  logic [RAMP_W-1:0]  lvl;
  logic               clp;

  assign total = {prod_r[52], prod_r}
               + $signed({{4{black_level[LEVEL_W-1]}}, black_level, 32'b0});
  assign adj = total[53] ? total + 54'sd4294967295 : total;
  assign q = adj[53:32];

  always_comb begin
    priority if (q[21]) begin
      lvl = ZERO_LEVEL;
      clp = 1'b1;
    end else if (q[20:16] != '0) begin
      lvl = FULL_SCALE;
      clp = 1'b1;
    end else begin
      lvl = q[15:0];
      clp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ramp_level <= lvl;
      clipped <= clp;
    end
  end

endmodule

// ----- rtl/grg_checker.sv -----
`timescale 1ns / 1ps
module grg_checker import grg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [RAMP_W-1:0] ramp_level,
  input logic              clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(ramp_level) && $stable(clipped))
    else $error("stalled output payload changed");

  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> ramp_level == ZERO_LEVEL || ramp_level == FULL_SCALE)
    else $error("clipped result is not at a rail");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gamma_ramp_generator_core grg_checker u_grg_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .ramp_level(ramp_level),
  .clipped(clipped)
);

// ----- verif/tb_gamma_ramp_generator_core.sv -----
`timescale 1ns / 1ps
module tb_gamma_ramp_generator_core;
  import grg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [RAMP_W-1:0] level;
    logic              clip;
  } ramp_entry_t;

  typedef struct {
    bit                 is_cfg;
    grg_reg_t           rsel;
    logic [LEVEL_W-1:0] value;
    bit                 typed;
    logic [RAMP_W-1:0]  level;
    logic               clip;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [INDEX_W-1:0] stop_index;
  logic               out_valid;
  logic               out_stall;
  logic [RAMP_W-1:0]  ramp_level;
  logic               clipped;
  logic               cfg_valid;
  logic               cfg_ready;
  grg_reg_t           cfg_index;
  logic [LEVEL_W-1:0] cfg_data;

  logic [STOP_W-1:0]  stops_q;
  logic [GAMMA_W-1:0] gamma_q;
  logic [LEVEL_W-1:0] black_q;
  logic [LEVEL_W-1:0] white_q;

  ramp_entry_t pending_ramp[$];
  ramp_entry_t typed_ramp[$];
  bit          typed_flag[$];
  int          error_count;
  int          idle_cycles;
  int          stall_mode;
  int          gap_max;
  int          burst_left;

  gamma_ramp_generator_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .stop_index (stop_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ramp_level (ramp_level),
    .clipped    (clipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] minus_log2_q30(logic [63:0] x);
    int          k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 0;
    frac = '0;
    while (k < 23 && (x >> (k + 1)) != 0) k++;
    m = x << (30 - k);
    for (int i = 30; i > 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac |= 64'd1 << (i - 1);
      end
    end
    return (64'(24 - k) << 30) - frac;
  endfunction

  function automatic logic [63:0] pow2_neg_q32(logic [63:0] y);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    n = y >> 30;
    f = y & ((64'd1 << 30) - 1);
    if (n >= 32) return '0;
    t = (f * 64'(LN2_Q32)) >> 30;
    term = 64'd1 << 32;
    sum = 64'd1 << 32;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * t) >> 32) / k;
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    return sum >> n;
  endfunction

  function automatic ramp_entry_t ramp_for_index(logic [INDEX_W-1:0] idx);
    logic [63:0] stops;
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] power;
    longint      black;
    longint      white;
    longint      total;
    longint      q;
    ramp_entry_t r;
    stops = 64'(stops_q);
    g = 64'(gamma_q);
    black = longint'($signed(black_q));
    white = longint'($signed(white_q));
    if (stops == 0) stops = 1;
    if (stops > 64'(MAX_STOPS)) stops = 64'(MAX_STOPS);
    if (g == 0) g = 1;
    if (64'(idx) >= stops) x = 64'd1 << 24;
    else x = (64'(idx) << 24) / stops;
    if (x == 0) power = '0;
    else if (x >= (64'd1 << 24)) power = 64'd1 << 32;
    else power = pow2_neg_q32((minus_log2_q30(x) * 4096) / g);
    total = longint'(power) * (white - black) + black * 64'sd4294967296;
    q = total / 64'sd4294967296;
    r.clip = 1'b0;
    if (q < 0) begin
      q = 0;
      r.clip = 1'b1;
    end else if (q > 65535) begin
      q = 65535;
      r.clip = 1'b1;
    end
    r.level = q[RAMP_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ramp_entry_t exp_r;
    ramp_entry_t typed_r;
    bit          moved;
    moved = 1'b0;
    if (rst) begin
      stops_q <= 13'd256;
      gamma_q <= 16'd9011;
      black_q <= '0;
      white_q <= 18'd65535;
    end else begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_STOP_COUNT: stops_q <= cfg_data[STOP_W-1:0];
          REG_GAMMA: gamma_q <= cfg_data[GAMMA_W-1:0];
          REG_BLACK: black_q <= cfg_data;
          REG_WHITE: white_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        exp_r = ramp_for_index(stop_index);
        typed_r = typed_ramp.pop_front();
        if (typed_flag.pop_front()) exp_r = typed_r;
        pending_ramp.push_back(exp_r);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_ramp.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transaction level=%0d clipped=%0b",
                   $time, ramp_level, clipped);
        end else begin
          exp_r = pending_ramp.pop_front();
          if (ramp_level !== exp_r.level) begin
            error_count++;
            $display("%0t: ramp_level expected %0d actual %0d",
                     $time, exp_r.level, ramp_level);
          end
          if (clipped !== exp_r.clip) begin
            error_count++;
            $display("%0t: clipped expected %0b actual %0b",
                     $time, exp_r.clip, clipped);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      3: out_stall <= ($time / 10) % 7 < 3;
      default: out_stall <= 1'b0;
    endcase
  end

  task automatic wait_drained();
    while (pending_ramp.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(grg_reg_t rsel, logic [LEVEL_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= rsel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_index(logic [INDEX_W-1:0] idx, bit typed, ramp_entry_t r);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(1, gap_max);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    stop_index <= idx;
    typed_flag.push_back(typed);
    typed_ramp.push_back(r);
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [LEVEL_W-1:0] random_level();
    case ($urandom_range(0, 5))
      0: return 18'h30001;
      1: return 18'h1FFFE;
      2: return 18'($urandom);
      default: return 18'($urandom_range(0, 65535));
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{0, REG_STOP_COUNT, 18'd0,     1, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd4095,  1, 16'd65535, 1'b0},
    '{0, REG_STOP_COUNT, 18'd1,     0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd128,   0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd255,   0, 16'd0,     1'b0},
    '{1, REG_BLACK,      18'h30001, 0, 16'd0,     1'b0},
    '{1, REG_WHITE,      18'h1FFFE, 0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd0,     1, 16'd0,     1'b1},
    '{0, REG_STOP_COUNT, 18'd4095,  1, 16'd65535, 1'b1},
    '{0, REG_STOP_COUNT, 18'd128,   0, 16'd0,     1'b0},
    '{1, REG_STOP_COUNT, 18'd0,     0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd0,     1, 16'd0,     1'b1},
    '{0, REG_STOP_COUNT, 18'd1,     1, 16'd65535, 1'b1},
    '{1, REG_STOP_COUNT, 18'd8191,  0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd4095,  0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd1,     0, 16'd0,     1'b0},
    '{1, REG_GAMMA,      18'd0,     0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd2048,  0, 16'd0,     1'b0},
    '{1, REG_GAMMA,      18'd410,   0, 16'd0,     1'b0},
    '{1, REG_BLACK,      18'd1000,  0, 16'd0,     1'b0},
    '{1, REG_WHITE,      18'd60000, 0, 16'd0,     1'b0},
    '{1, REG_STOP_COUNT, 18'd4096,  0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd1,     1, 16'd1000,  1'b0},
    '{0, REG_STOP_COUNT, 18'd4095,  0, 16'd0,     1'b0},
    '{1, REG_GAMMA,      18'd65535, 0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd1,     0, 16'd0,     1'b0},
    '{0, REG_STOP_COUNT, 18'd3000,  0, 16'd0,     1'b0}
  };

  initial begin
    ramp_entry_t r;
    int          stops;
    int          pick;
    error_count = 0;
    idle_cycles = 0;
    stall_mode = 0;
    gap_max = 0;
    burst_left = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    stop_index = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_STOP_COUNT;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_reg(directed[i].rsel, directed[i].value);
      end else begin
        r.level = directed[i].level;
        r.clip = directed[i].clip;
        send_index(directed[i].value[INDEX_W-1:0], directed[i].typed, r);
      end
    end

    r.level = '0;
    r.clip = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) stops = 1;
      else if (pick == 1) stops = 4096;
      else if (pick == 2) stops = $urandom_range(0, 8191);
      else stops = $urandom_range(2, 4096);
      write_reg(REG_STOP_COUNT, 18'(stops));
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(REG_GAMMA, 18'd410);
      else if (pick == 1) write_reg(REG_GAMMA, 18'd65535);
      else if (pick == 2) write_reg(REG_GAMMA, 18'($urandom_range(0, 65535)));
      else write_reg(REG_GAMMA, 18'($urandom_range(2048, 16384)));
      write_reg(REG_BLACK, random_level());
      write_reg(REG_WHITE, random_level());
      stall_mode = phase % 4;
      gap_max = (phase == 0) ? 0 : $urandom_range(2, 10);
      if (stops == 0) stops = 1;
      if (stops > 4096) stops = 4096;
      repeat (250) begin
        if ($urandom_range(0, 9) == 0)
          send_index(INDEX_W'($urandom), 1'b0, r);
        else
          send_index(INDEX_W'($urandom_range(0, stops - 1)), 1'b0, r);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/grg_pkg.sv
rtl/grg_div.sv
rtl/grg_log2.sv
rtl/grg_exp2.sv
rtl/gamma_ramp_generator_core.sv
rtl/grg_checker.sv
verif/tb_gamma_ramp_generator_core.sv
